>>> design/sefr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sefr_pkg;

   localparam int unsigned MAX_DEPTH = 255;
   localparam int unsigned DEPTH_W = 8;
   localparam int unsigned LEN_W = 16;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd4096;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_CLEAN_END = 3'd1;
   localparam logic [2:0] ST_UNEXP_END = 3'd2;
   localparam logic [2:0] ST_BUF_FULL = 3'd3;
   localparam logic [2:0] ST_DEPTH_OVF = 3'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       form_end;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   // everything one input item produces
   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    two;
   } entry_type;

endpackage

`default_nettype wire

>>> design/sefr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sefr_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [15:0]         csr_wdata,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire sefr_pkg::req_type   req_data,
   output logic                     push_valid,
   output sefr_pkg::entry_type      push_entry,
   input  wire logic                queue_ready
);

   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_LBRK   = 8'h5b;
   localparam logic [7:0] CH_LBRC   = 8'h7b;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_RBRK   = 8'h5d;
   localparam logic [7:0] CH_RBRC   = 8'h7d;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_BQUOTE = 8'h60;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;

   typedef enum logic [9:0] {
      M_IDLE       = 10'b0000000001,
      M_IDLE_CMT   = 10'b0000000010,
      M_PREFIX     = 10'b0000000100,
      M_PREFIX_CMT = 10'b0000001000,
      M_COMMA      = 10'b0000010000,
      M_ATOM       = 10'b0000100000,
      M_DELIM      = 10'b0001000000,
      M_DELIM_CMT  = 10'b0010000000,
      M_STR        = 10'b0100000000,
      M_STR_ESC    = 10'b1000000000
   } mode_type;

   typedef struct packed {
      logic                            emit;
      sefr_pkg::rsp_type               res;
      mode_type                        mode;
      logic [sefr_pkg::DEPTH_W-1:0]    depth;
      logic [sefr_pkg::LEN_W-1:0]      len;
   } start_type;

   mode_type                      mode_ff, mode_in;
   logic [sefr_pkg::DEPTH_W-1:0]  depth_ff, depth_in;
   logic [sefr_pkg::LEN_W-1:0]    len_ff, len_in;
   logic                          nested_ff, nested_in;
   logic [sefr_pkg::LEN_W-1:0]    max_len_ff;

   sefr_pkg::rsp_type r0, r1;
   logic              has0, two;
   logic              accept;
   logic              full;
   logic [7:0]        c;
   logic [sefr_pkg::DEPTH_W-1:0] depth_dec;
   start_type         s;

   function automatic sefr_pkg::rsp_type byte_res(input logic [7:0] b);
      sefr_pkg::rsp_type r;
      r = '0;
      r.out_byte = b;
      r.byte_valid = 1'b1;
      return r;
   endfunction

   function automatic sefr_pkg::rsp_type end_res(input logic [2:0] st);
      sefr_pkg::rsp_type r;
      r = '0;
      r.form_end = 1'b1;
      r.status = st;
      return r;
   endfunction

   function automatic logic is_ws(input logic [7:0] b);
      return b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
   endfunction

   function automatic logic is_open(input logic [7:0] b);
      return b inside {CH_LPAR, CH_LBRK, CH_LBRC};
   endfunction

   function automatic logic is_close(input logic [7:0] b);
      return b inside {CH_RPAR, CH_RBRK, CH_RBRC};
   endfunction

   // first byte of a form, or first byte after a prefix mark
   function automatic start_type start_byte(input logic [7:0] b, input logic after_prefix,
                                            input logic is_full,
                                            input logic [sefr_pkg::LEN_W-1:0] len);
      start_type t;
      t.emit = 1'b0;
      t.res = '0;
      t.mode = after_prefix ? M_PREFIX : M_IDLE;
      t.depth = '0;
      t.len = len;
      if (b == CH_SEMI) begin
         t.mode = after_prefix ? M_PREFIX_CMT : M_IDLE_CMT;
      end else if (is_ws(b)) begin
         t.emit = 1'b0;
      end else if (is_full) begin
         t.emit = 1'b1;
         t.res = end_res(sefr_pkg::ST_BUF_FULL);
         t.mode = M_IDLE;
         t.len = '0;
      end else begin
         t.emit = 1'b1;
         t.res = byte_res(b);
         t.len = len + 1'b1;
         if (is_open(b)) begin
            t.depth = sefr_pkg::DEPTH_W'(1);
            t.mode = M_DELIM;
         end else if (b == CH_DQUOTE) begin
            t.mode = M_STR;
         end else if (b inside {CH_QUOTE, CH_BQUOTE, CH_HASH}) begin
            t.mode = M_PREFIX;
         end else if (b == CH_COMMA) begin
            t.mode = M_COMMA;
         end else begin
            t.mode = M_ATOM;
         end
      end
      return t;
   endfunction

   assign req_ready = queue_ready;
   assign accept = req_valid && queue_ready;
   assign c = req_data.in_byte;
   assign full = len_ff >= max_len_ff;
   assign depth_dec = (depth_ff != '0) ? depth_ff - 1'b1 : depth_ff;

   always_comb begin
      mode_in = mode_ff;
      depth_in = depth_ff;
      len_in = len_ff;
      nested_in = nested_ff;
      r0 = '0;
      r1 = '0;
      has0 = 1'b0;
      two = 1'b0;
      s = '0;
      if (req_data.end_of_input) begin
         has0 = 1'b1;
         mode_in = M_IDLE;
         depth_in = '0;
         len_in = '0;
         nested_in = 1'b0;
         case (mode_ff)
            M_IDLE, M_IDLE_CMT: begin
               r0 = end_res(sefr_pkg::ST_CLEAN_END);
            end
            M_ATOM: begin
               r0 = end_res(sefr_pkg::ST_OK);
               r1 = end_res(sefr_pkg::ST_CLEAN_END);
               two = 1'b1;
            end
            default: begin
               r0 = end_res(sefr_pkg::ST_UNEXP_END);
            end
         endcase
      end else begin
         case (mode_ff)
            M_IDLE, M_PREFIX: begin
               s = start_byte(c, mode_ff == M_PREFIX, full, len_ff);
               has0 = s.emit;
               r0 = s.res;
               mode_in = s.mode;
               depth_in = s.depth;
               len_in = s.len;
               nested_in = 1'b0;
            end
            M_IDLE_CMT: begin
               if (c == CH_LF) mode_in = M_IDLE;
            end
            M_PREFIX_CMT: begin
               if (c == CH_LF) mode_in = M_PREFIX;
            end
            M_DELIM_CMT: begin
               if (c == CH_LF) mode_in = M_DELIM;
            end
            M_COMMA: begin
               if (c == CH_AT) begin
                  has0 = 1'b1;
                  if (full) begin
                     r0 = end_res(sefr_pkg::ST_BUF_FULL);
                     mode_in = M_IDLE;
                     depth_in = '0;
                     len_in = '0;
                     nested_in = 1'b0;
                  end else begin
                     r0 = byte_res(c);
                     len_in = len_ff + 1'b1;
                     mode_in = M_PREFIX;
                  end
               end else begin
                  s = start_byte(c, 1'b1, full, len_ff);
                  has0 = s.emit;
                  r0 = s.res;
                  mode_in = s.mode;
                  depth_in = s.depth;
                  len_in = s.len;
                  nested_in = 1'b0;
               end
            end
            M_ATOM: begin
               has0 = 1'b1;
               if (is_ws(c)) begin
                  r0 = end_res(sefr_pkg::ST_OK);
                  mode_in = M_IDLE;
                  depth_in = '0;
                  len_in = '0;
                  nested_in = 1'b0;
               end else if (is_open(c) || is_close(c)) begin
                  // the bracket ends the atom and opens the next form
                  r0 = end_res(sefr_pkg::ST_OK);
                  s = start_byte(c, 1'b0, max_len_ff == '0, '0);
                  r1 = s.res;
                  two = s.emit;
                  mode_in = s.mode;
                  depth_in = s.depth;
                  len_in = s.len;
                  nested_in = 1'b0;
               end else if (full) begin
                  r0 = end_res(sefr_pkg::ST_BUF_FULL);
                  mode_in = M_IDLE;
                  depth_in = '0;
                  len_in = '0;
                  nested_in = 1'b0;
               end else begin
                  r0 = byte_res(c);
                  len_in = len_ff + 1'b1;
               end
            end
            M_DELIM: begin
               if (c == CH_SEMI) begin
                  mode_in = M_DELIM_CMT;
               end else if (full) begin
                  has0 = 1'b1;
                  r0 = end_res(sefr_pkg::ST_BUF_FULL);
                  mode_in = M_IDLE;
                  depth_in = '0;
                  len_in = '0;
                  nested_in = 1'b0;
               end else if (is_open(c) &&
                            depth_ff >= sefr_pkg::DEPTH_W'(sefr_pkg::MAX_DEPTH)) begin
                  has0 = 1'b1;
                  r0 = end_res(sefr_pkg::ST_DEPTH_OVF);
                  mode_in = M_IDLE;
                  depth_in = '0;
                  len_in = '0;
                  nested_in = 1'b0;
               end else begin
                  has0 = 1'b1;
                  r0 = byte_res(c);
                  len_in = len_ff + 1'b1;
                  if (c == CH_DQUOTE) begin
                     nested_in = 1'b1;
                     mode_in = M_STR;
                  end else if (is_open(c)) begin
                     depth_in = depth_ff + 1'b1;
                  end else if (is_close(c)) begin
                     depth_in = depth_dec;
                     if (depth_dec == '0) begin
                        r0.form_end = 1'b1;
                        mode_in = M_IDLE;
                        len_in = '0;
                        nested_in = 1'b0;
                     end
                  end
               end
            end
            M_STR, M_STR_ESC: begin
               has0 = 1'b1;
               if (full) begin
                  r0 = end_res(sefr_pkg::ST_BUF_FULL);
                  mode_in = M_IDLE;
                  depth_in = '0;
                  len_in = '0;
                  nested_in = 1'b0;
               end else begin
                  r0 = byte_res(c);
                  len_in = len_ff + 1'b1;
                  if (mode_ff == M_STR_ESC) begin
                     mode_in = M_STR;
                  end else if (c == CH_BSLASH) begin
                     mode_in = M_STR_ESC;
                  end else if (c == CH_DQUOTE) begin
                     if (nested_ff) begin
                        nested_in = 1'b0;
                        mode_in = M_DELIM;
                     end else begin
                        r0.form_end = 1'b1;
                        mode_in = M_IDLE;
                        depth_in = '0;
                        len_in = '0;
                        nested_in = 1'b0;
                     end
                  end
               end
            end
            default: begin
               mode_in = M_IDLE;
               depth_in = '0;
               len_in = '0;
               nested_in = 1'b0;
            end
         endcase
      end
      if (two) r1.last = 1'b1;
      else r0.last = 1'b1;
   end

   assign push_valid = accept && has0;
   assign push_entry.first = r0;
   assign push_entry.second = r1;
   assign push_entry.two = two;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         depth_ff <= '0;
         len_ff <= '0;
         nested_ff <= 1'b0;
         max_len_ff <= sefr_pkg::MAX_LEN_RESET;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            depth_ff <= depth_in;
            len_ff <= len_in;
            nested_ff <= nested_in;
         end
         if (csr_we) max_len_ff <= csr_wdata;
      end
   end

endmodule

`default_nettype wire

>>> design/sefr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sefr_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire sefr_pkg::entry_type  push_entry,
   output logic                      push_ready,
   output logic                      pop_valid,
   output sefr_pkg::entry_type       pop_entry,
   input  wire logic                 pop
);

   localparam int unsigned PTR_W = $clog2(sefr_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(sefr_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(sefr_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(sefr_pkg::QUEUE_DEPTH);

   sefr_pkg::entry_type slot_ff [sefr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = cnt_ff != FULL_CNT;
   assign pop_valid = cnt_ff != '0;
   assign pop_entry = slot_ff[rd_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      if (do_pop) rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

>>> design/sefr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sefr_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   input  wire sefr_pkg::entry_type  pop_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sefr_pkg::rsp_type         rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   sefr_pkg::rsp_type rsp_ff, rsp_in;
   logic              pend_ff, pend_in;
   sefr_pkg::rsp_type pend_data_ff, pend_data_in;
   logic              slot_free;
   logic              load_pend;

   // the output register is free when empty or being taken this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign load_pend = pend_ff && slot_free;
   assign pop = pop_valid && !pend_ff && slot_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      pend_in = pend_ff;
      pend_data_in = pend_data_ff;
      if (slot_free) rsp_valid_in = pend_ff || pop_valid;
      if (load_pend) begin
         rsp_in = pend_data_ff;
         pend_in = 1'b0;
      end else if (pop) begin
         rsp_in = pop_entry.first;
         pend_in = pop_entry.two;
         pend_data_in = pop_entry.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      pend_data_ff <= pend_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> design/s_expression_form_framer_unit.sv
// s-expression form framer
// req channel: one source byte a beat, or an end-of-input mark (in_byte ignored).
// rsp channel: one result a beat; a kept byte (byte_valid) and/or a form end
//   (form_end with status: ok, clean end, unexpected end, buffer full, depth
//   overflow). last marks the final result caused by one request beat.
// csr port: csr_we writes max_form_len from csr_wdata at once; write only while
//   no request is in flight.
// path: a result is written into the queue, then moved into the output register
//   that drives rsp. Skipped bytes give no result.
// throughput: one request beat per cycle while the queue has room; the rsp side
//   drains one result per cycle while rsp_ready is high, so a beat that gives two
//   results (end of an atom at a bracket or at end of input) sends them in turn.
// the parser front writes into a 4-entry queue; req_ready drops only when that
//   queue is full, so a stalled receiver backs up the queue first, then req.
// reset: synchronous; parser goes idle between forms, depth and length clear,
//   max_form_len returns to 4096, queue and output register empty.
`timescale 1ns / 1ps
`default_nettype none

module s_expression_form_framer_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [15:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire sefr_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output sefr_pkg::rsp_type       rsp_data
);

   logic                push_valid;
   logic                push_ready;
   sefr_pkg::entry_type push_entry;
   logic                pop_valid;
   logic                pop;
   sefr_pkg::entry_type pop_entry;

   sefr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .push_valid  (push_valid),
      .push_entry  (push_entry),
      .queue_ready (push_ready)
   );

   sefr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   sefr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> design/sefr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sefr_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire sefr_pkg::rsp_type  rsp_data
);

   // a held result may not change under backpressure
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // every result carries a byte or a form end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.byte_valid || rsp_data.form_end)
      else $error("empty rsp beat");

   // status only on form end, and always a defined code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.form_end || rsp_data.status == sefr_pkg::ST_OK) &&
                    rsp_data.status <= sefr_pkg::ST_DEPTH_OVF)
      else $error("bad rsp status");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // the queue is empty after reset, so a request can be taken at once
   assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready after reset");

endmodule

bind s_expression_form_framer_unit sefr_checker u_sefr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> test/framer_checker.sv
`timescale 1ns / 1ps

package framer_tb_pkg;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_LSQUARE = "[";
   localparam logic [7:0] CH_LCURLY = "{";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_RSQUARE = "]";
   localparam logic [7:0] CH_RCURLY = "}";
   localparam logic [7:0] CH_SEMI = ";";
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_BACKQUOTE = 8'h60;
   localparam logic [7:0] CH_HASH = "#";
   localparam logic [7:0] CH_COMMA = ",";
   localparam logic [7:0] CH_AT = "@";

   function automatic bit is_space(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic bit is_open(logic [7:0] c);
      return c == CH_LPAREN || c == CH_LSQUARE || c == CH_LCURLY;
   endfunction

   function automatic bit is_close(logic [7:0] c);
      return c == CH_RPAREN || c == CH_RSQUARE || c == CH_RCURLY;
   endfunction

endpackage

module framer_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [15:0]        csr_wdata,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire sefr_pkg::req_type  req_data,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire sefr_pkg::rsp_type  rsp_data,
   output int                      mismatches,
   output int                      waiting,
   output int                      req_beats,
   output int                      results_seen,
   output int                      kept_bytes,
   output int                      forms_ok,
   output int                      clean_ends,
   output int                      error_ends
);

   import sefr_pkg::*;
   import framer_tb_pkg::*;

   typedef enum logic [3:0] {
      SCAN_IDLE,
      SCAN_IDLE_NOTE,
      SCAN_PREFIX,
      SCAN_PREFIX_NOTE,
      SCAN_COMMA,
      SCAN_ATOM,
      SCAN_LIST,
      SCAN_LIST_NOTE,
      SCAN_STRING,
      SCAN_ESCAPE
   } scan_mode_e;

   scan_mode_e          scan;
   logic [DEPTH_W-1:0]  nest;
   logic [LEN_W-1:0]    flen;
   logic [LEN_W-1:0]    max_len;
   logic                str_in_list;

   rsp_type beat_results[$];
   rsp_type pending_results[$];

   function automatic void put(logic [7:0] b, logic kept, logic fend, logic [2:0] st);
      rsp_type r;
      r.out_byte = b;
      r.byte_valid = kept;
      r.form_end = fend;
      r.status = st;
      r.last = 1'b0;
      beat_results.push_back(r);
   endfunction

   function automatic void drop_form();
      scan = SCAN_IDLE;
      nest = '0;
      flen = '0;
      str_in_list = 1'b0;
   endfunction

   function automatic void abort_form(logic [2:0] st);
      put(8'h00, 1'b0, 1'b1, st);
      drop_form();
   endfunction

   function automatic bit append(logic [7:0] c);
      if (flen >= max_len) begin
         abort_form(ST_BUF_FULL);
         return 1'b0;
      end
      flen++;
      put(c, 1'b1, 1'b0, ST_OK);
      return 1'b1;
   endfunction

   // the byte just appended closes the form
   function automatic void close_form();
      rsp_type r;
      r = beat_results.pop_back();
      r.form_end = 1'b1;
      beat_results.push_back(r);
      drop_form();
   endfunction

   function automatic void start_form(logic [7:0] c, bit after_prefix);
      if (c == CH_SEMI) begin
         scan = after_prefix ? SCAN_PREFIX_NOTE : SCAN_IDLE_NOTE;
      end else if (is_space(c)) begin
         scan = after_prefix ? SCAN_PREFIX : SCAN_IDLE;
      end else if (append(c)) begin
         if (is_open(c)) begin
            nest = DEPTH_W'(1);
            scan = SCAN_LIST;
         end else if (c == CH_DQUOTE) begin
            str_in_list = 1'b0;
            scan = SCAN_STRING;
         end else if (c == CH_QUOTE || c == CH_BACKQUOTE || c == CH_HASH) begin
            scan = SCAN_PREFIX;
         end else if (c == CH_COMMA) begin
            scan = SCAN_COMMA;
         end else begin
            scan = SCAN_ATOM;
         end
      end
   endfunction

   task automatic frame_beat(req_type rq);
      logic [7:0] c;
      rsp_type    r;
      c = rq.in_byte;
      beat_results.delete();
      if (rq.end_of_input) begin
         if (scan == SCAN_IDLE || scan == SCAN_IDLE_NOTE) begin
            put(8'h00, 1'b0, 1'b1, ST_CLEAN_END);
            drop_form();
         end else if (scan == SCAN_ATOM) begin
            put(8'h00, 1'b0, 1'b1, ST_OK);
            put(8'h00, 1'b0, 1'b1, ST_CLEAN_END);
            drop_form();
         end else begin
            abort_form(ST_UNEXP_END);
         end
      end else begin
         case (scan)
            SCAN_IDLE: start_form(c, 1'b0);
            SCAN_PREFIX: start_form(c, 1'b1);
            SCAN_IDLE_NOTE: if (c == CH_LF) scan = SCAN_IDLE;
            SCAN_PREFIX_NOTE: if (c == CH_LF) scan = SCAN_PREFIX;
            SCAN_LIST_NOTE: if (c == CH_LF) scan = SCAN_LIST;
            SCAN_COMMA: begin
               if (c == CH_AT) begin
                  if (append(c)) scan = SCAN_PREFIX;
               end else begin
                  start_form(c, 1'b1);
               end
            end
            SCAN_ATOM: begin
               if (is_space(c)) begin
                  put(8'h00, 1'b0, 1'b1, ST_OK);
                  drop_form();
               end else if (is_open(c) || is_close(c)) begin
                  // a bracket ends the atom and opens the next form
                  put(8'h00, 1'b0, 1'b1, ST_OK);
                  drop_form();
                  start_form(c, 1'b0);
               end else begin
                  void'(append(c));
               end
            end
            SCAN_LIST: begin
               if (c == CH_SEMI) begin
                  scan = SCAN_LIST_NOTE;
               end else if (c == CH_DQUOTE) begin
                  if (append(c)) begin
                     str_in_list = 1'b1;
                     scan = SCAN_STRING;
                  end
               end else if (is_open(c)) begin
                  // length is checked ahead of depth
                  if (flen >= max_len) abort_form(ST_BUF_FULL);
                  else if (nest >= MAX_DEPTH) abort_form(ST_DEPTH_OVF);
                  else begin
                     void'(append(c));
                     nest++;
                  end
               end else if (append(c) && is_close(c)) begin
                  if (nest > 0) nest--;
                  if (nest == 0) close_form();
               end
            end
            SCAN_STRING: begin
               if (append(c)) begin
                  if (c == CH_BSLASH) begin
                     scan = SCAN_ESCAPE;
                  end else if (c == CH_DQUOTE) begin
                     if (str_in_list) begin
                        str_in_list = 1'b0;
                        scan = SCAN_LIST;
                     end else begin
                        close_form();
                     end
                  end
               end
            end
            SCAN_ESCAPE: if (append(c)) scan = SCAN_STRING;
            default: drop_form();
         endcase
      end
      if (beat_results.size() > 0) begin
         r = beat_results.pop_back();
         r.last = 1'b1;
         beat_results.push_back(r);
      end
      foreach (beat_results[i]) pending_results.push_back(beat_results[i]);
   endtask

   function automatic string show(rsp_type r);
      return $sformatf("byte %h kept %b end %b status %0d last %b",
                       r.out_byte, r.byte_valid, r.form_end, r.status, r.last);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         drop_form();
         max_len = MAX_LEN_RESET;
         pending_results.delete();
         mismatches = 0;
         req_beats = 0;
         results_seen = 0;
         kept_bytes = 0;
         forms_ok = 0;
         clean_ends = 0;
         error_ends = 0;
      end else begin
         if (csr_we) max_len = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_data.byte_valid) kept_bytes++;
            if (rsp_data.form_end) begin
               case (rsp_data.status)
                  ST_OK: forms_ok++;
                  ST_CLEAN_END: clean_ends++;
                  default: error_ends++;
               endcase
            end
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result at %0t: %s", $realtime, show(rsp_data));
            end else begin
               want = pending_results.pop_front();
               if (want.out_byte !== rsp_data.out_byte ||
                   want.byte_valid !== rsp_data.byte_valid ||
                   want.form_end !== rsp_data.form_end ||
                   want.status !== rsp_data.status ||
                   want.last !== rsp_data.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch at %0t", $realtime);
                     $display("   expected %s", show(want));
                     $display("   actual   %s", show(rsp_data));
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            req_beats++;
            frame_beat(req_data);
         end
      end
      waiting <= pending_results.size();
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   import sefr_pkg::*;
   import framer_tb_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;

   int mismatches;
   int waiting;
   int req_beats;
   int results_seen;
   int kept_bytes;
   int forms_ok;
   int clean_ends;
   int error_ends;

   req_type src_q[$];
   int      phase_items;
   int      tx_calm;
   int      rx_calm;
   bit      hold_off;
   bit      hold_done;

   s_expression_form_framer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   framer_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .mismatches   (mismatches),
      .waiting      (waiting),
      .req_beats    (req_beats),
      .results_seen (results_seen),
      .kept_bytes   (kept_bytes),
      .forms_ok     (forms_ok),
      .clean_ends   (clean_ends),
      .error_ends   (error_ends)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // mostly no gap, some short ones, a few long ones, and now and then a calm stretch with none
   function automatic int idle_len(inout int calm);
      int k;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      k = $urandom_range(0, 99);
      if (k < 5) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (k < 55) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void add_byte(logic [7:0] b, bit counted);
      req_type beat;
      beat.in_byte = b;
      beat.end_of_input = 1'b0;
      src_q.push_back(beat);
      if (counted) phase_items++;
   endfunction

   function automatic void add_end();
      req_type beat;
      beat.in_byte = 8'($urandom_range(0, 255));
      beat.end_of_input = 1'b1;
      src_q.push_back(beat);
      phase_items++;
   endfunction

   function automatic logic [7:0] space_char();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   function automatic logic [7:0] open_char();
      case ($urandom_range(0, 2))
         0: return CH_LPAREN;
         1: return CH_LSQUARE;
         default: return CH_LCURLY;
      endcase
   endfunction

   function automatic logic [7:0] close_char();
      case ($urandom_range(0, 2))
         0: return CH_RPAREN;
         1: return CH_RSQUARE;
         default: return CH_RCURLY;
      endcase
   endfunction

   function automatic logic [7:0] atom_more();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (is_space(b) || is_open(b) || is_close(b));
      return b;
   endfunction

   function automatic logic [7:0] atom_start();
      logic [7:0] b;
      do b = atom_more();
      while (b == CH_SEMI || b == CH_DQUOTE || b == CH_QUOTE || b == CH_BACKQUOTE ||
             b == CH_HASH || b == CH_COMMA);
      return b;
   endfunction

   // whitespace and line comments; a leading space keeps an atom from running on
   function automatic void add_filler(bit need_space);
      logic [7:0] b;
      if (need_space || $urandom_range(0, 1)) add_byte(space_char(), 1'b1);
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 2) == 0) begin
            add_byte(CH_SEMI, 1'b1);
            repeat ($urandom_range(0, 5)) begin
               b = 8'($urandom_range(0, 255));
               if (b != CH_LF) add_byte(b, 1'b1);
            end
            add_byte(CH_LF, 1'b1);
         end else begin
            add_byte(space_char(), 1'b1);
         end
      end
   endfunction

   function automatic void gen_form(int lvl);
      int         kind;
      logic [7:0] b;
      kind = (lvl >= 4) ? $urandom_range(0, 4) : $urandom_range(0, 9);
      if (kind <= 3) begin
         add_byte(atom_start(), 1'b1);
         repeat ($urandom_range(0, 5)) add_byte(atom_more(), 1'b1);
      end else if (kind == 4) begin
         add_byte(CH_DQUOTE, 1'b1);
         repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
               add_byte(CH_BSLASH, 1'b1);
               add_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
               do b = 8'($urandom_range(0, 255));
               while (b == CH_DQUOTE || b == CH_BSLASH);
               add_byte(b, 1'b1);
            end
         end
         add_byte(CH_DQUOTE, 1'b1);
      end else if (kind == 5) begin
         case ($urandom_range(0, 4))
            0: add_byte(CH_QUOTE, 1'b1);
            1: add_byte(CH_BACKQUOTE, 1'b1);
            2: add_byte(CH_HASH, 1'b1);
            3: add_byte(CH_COMMA, 1'b1);
            default: begin
               add_byte(CH_COMMA, 1'b1);
               add_byte(CH_AT, 1'b1);
            end
         endcase
         if ($urandom_range(0, 3) == 0) add_filler(1'b0);
         gen_form(lvl + 1);
      end else begin
         add_byte(open_char(), 1'b1);
         repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 1)) add_filler(1'b0);
            gen_form(lvl + 1);
         end
         add_byte(close_char(), 1'b1);
      end
   endfunction

   task automatic send_beat(req_type beat);
      int gap;
      gap = idle_len(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_all();
      while (src_q.size() > 0) send_beat(src_q.pop_front());
   endtask

   task automatic one_piece();
      int k;
      int mark;
      int cut;
      k = $urandom_range(0, 99);
      if (k < 80) begin
         gen_form(0);
         add_filler(1'b1);
      end else if (k < 88) begin
         // form cut short by end of input
         mark = src_q.size();
         gen_form(0);
         cut = $urandom_range(mark, src_q.size() - 1);
         while (src_q.size() > cut) void'(src_q.pop_back());
         add_end();
      end else if (k < 95) begin
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)), 1'b1);
         if ($urandom_range(0, 1)) add_end();
      end else begin
         add_end();
      end
      send_all();
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_phase(logic [15:0] len_limit, int budget, bit deep);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= len_limit;
      @(posedge clock);
      csr_we <= 1'b0;
      phase_items = 0;
      if (deep) begin
         // one bracket past the depth limit
         repeat (MAX_DEPTH + 1) add_byte(open_char(), 1'b1);
         add_end();
         send_all();
      end
      while (phase_items < budget) one_piece();
   endtask

   // receiver
   initial begin
      int gap;
      int burst;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
         end
         gap = idle_len(rx_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         burst = $urandom_range(1, 12);
         repeat (burst) @(posedge clock);
      end
   end

   // sender and verdict
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      add_end();
      add_byte(CH_SEMI, 1'b1);
      add_byte(CH_LF, 1'b1);
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      add_byte(CH_SPACE, 1'b1);
      add_byte(CH_RPAREN, 1'b1);
      add_byte(CH_LPAREN, 1'b1);
      add_byte(CH_DQUOTE, 1'b1);
      add_byte(CH_BSLASH, 1'b1);
      add_byte(CH_DQUOTE, 1'b1);
      add_byte(CH_DQUOTE, 1'b1);
      add_byte(CH_SEMI, 1'b1);
      add_byte(CH_LF, 1'b1);
      add_byte(CH_RSQUARE, 1'b1);
      add_byte(CH_COMMA, 1'b1);
      add_byte(CH_AT, 1'b1);
      add_byte(CH_QUOTE, 1'b1);
      add_byte("z", 1'b1);
      add_byte(CH_TAB, 1'b1);
      add_byte(CH_BACKQUOTE, 1'b1);
      add_end();
      add_byte("k", 1'b1);
      add_end();
      send_all();

      // receiver stalls long while the sender keeps going
      hold_off = 1'b1;
      phase_items = 0;
      while (phase_items < 135) one_piece();

      run_phase(16'hFFFF, 135, 1'b1);
      run_phase(16'd1, 135, 1'b0);
      run_phase(16'd3, 135, 1'b0);
      run_phase(16'd2, 135, 1'b0);
      run_phase(16'($urandom_range(4, 24)), 135, 1'b0);
      run_phase(16'd300, 135, 1'b0);
      run_phase(MAX_LEN_RESET, 135, 1'b0);

      settle();
      repeat (60) @(posedge clock);

      $display("covered %0d request beats and %0d results with %0d kept bytes",
               req_beats, results_seen, kept_bytes);
      $display("forms ended ok %0d, clean input ends %0d, error ends %0d",
               forms_ok, clean_ends, error_ends);
      if (mismatches == 0 && waiting == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
